// ----- rtl/tfr_pkg.sv -----
// ----------------------------------------------------------------------------
// tfr_pkg
// shared types and constants of the timed frame receiver and command decoder
// ----------------------------------------------------------------------------
`default_nettype none

package tfr_pkg;

    localparam logic [7:0] HDR_ADDRESSED = 8'hFD;
    localparam logic [7:0] HDR_BROADCAST = 8'h00;
    localparam logic [7:0] OP_SETTINGS   = 8'h00;
    localparam logic [7:0] OP_PING       = 8'h01;

    // fixed byte positions inside a frame
    localparam int IDX_HDR      = 0;
    localparam int IDX_LEN      = 1;
    localparam int IDX_BCAST_OP = 2;
    localparam int IDX_OP       = 4;
    localparam int IDX_LIGHT    = 5;
    localparam int IDX_MOTION   = 6;
    localparam int IDX_MUTE     = 7;

    localparam int MIN_BCAST_LEN  = 5;
    localparam int MIN_ADDR_LEN   = 7;
    localparam int ADDR_OVERHEAD  = 6;
    localparam int MIN_CONFIG_LEN = 10;

    localparam logic [1:0] ACT_DROP  = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_HELLO = 2'd2;

    localparam logic CFG_IDX_LIMIT = 1'b0;
    localparam logic CFG_IDX_COORD = 1'b1;

    typedef struct packed {
        logic len_bcast;   // count >= 5
        logic len_addr;    // count >= 7
        logic len_config;  // count >= 10
        logic len_match;   // length byte equals count - 6
    } len_flags_t;

    // one closed frame, reduced to the bytes the decoder looks at
    typedef struct packed {
        logic [7:0]  hdr;
        logic [7:0]  bcast_op;
        logic [7:0]  op;
        logic [7:0]  light;
        logic [7:0]  motion;
        logic [7:0]  mute;
        logic [15:0] src;
        len_flags_t  flags;
    } frame_rec_t;

endpackage

`default_nettype wire

// ----- rtl/tfr_front.sv -----
// ----------------------------------------------------------------------------
// tfr_front
// collects received bytes, counts window ticks and hands closed frames on
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_front
    import tfr_pkg::*;
#(
    parameter int FRAME_DEPTH = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,
    input  wire logic       s_axis_tuser,
    input  wire logic [7:0] limit,
    input  wire logic       q_full,
    output logic            q_push,
    output frame_rec_t      q_rec
);

    localparam int CNT_W = $clog2(FRAME_DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       tick_reg, tick_next;
    logic [7:0]       hdr_reg, len_reg, bcast_op_reg, op_reg;
    logic [7:0]       light_reg, motion_reg, mute_reg;
    logic [7:0]       src_hi_reg, src_lo_reg;
    logic             accept, is_byte, is_tick, receiving, wr_en, close;
    logic [8:0]       len_expect;

    assign s_axis_tready = !q_full;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign is_byte   = accept && !s_axis_tuser;
    assign is_tick   = accept && s_axis_tuser;
    assign receiving = (count_reg != '0);
    assign wr_en     = is_byte && (count_reg != CNT_W'(FRAME_DEPTH));
    assign tick_next = tick_reg + 8'd1;
    assign close     = is_tick && receiving && (tick_next > limit);
    assign q_push    = close;

    always_comb
    begin
        count_next = count_reg;
        if (close)
        begin
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            tick_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (is_byte && !receiving)
            begin
                tick_reg <= '0;
            end
            else if (is_tick && receiving)
            begin
                tick_reg <= tick_next;
            end
        end
    end

    // only the fixed positions and the last two stored bytes matter to the decoder
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            src_hi_reg <= src_lo_reg;
            src_lo_reg <= s_axis_tdata;
            if (count_reg == CNT_W'(IDX_HDR))      hdr_reg      <= s_axis_tdata;
            if (count_reg == CNT_W'(IDX_LEN))      len_reg      <= s_axis_tdata;
            if (count_reg == CNT_W'(IDX_BCAST_OP)) bcast_op_reg <= s_axis_tdata;
            if (count_reg == CNT_W'(IDX_OP))       op_reg       <= s_axis_tdata;
            if (count_reg == CNT_W'(IDX_LIGHT))    light_reg    <= s_axis_tdata;
            if (count_reg == CNT_W'(IDX_MOTION))   motion_reg   <= s_axis_tdata;
            if (count_reg == CNT_W'(IDX_MUTE))     mute_reg     <= s_axis_tdata;
        end
    end

    assign len_expect = 9'(count_reg) - 9'(ADDR_OVERHEAD);

    always_comb
    begin
        q_rec.hdr              = hdr_reg;
        q_rec.bcast_op         = bcast_op_reg;
        q_rec.op               = op_reg;
        q_rec.light            = light_reg;
        q_rec.motion           = motion_reg;
        q_rec.mute             = mute_reg;
        q_rec.src              = {src_hi_reg, src_lo_reg};
        q_rec.flags.len_bcast  = (count_reg >= CNT_W'(MIN_BCAST_LEN));
        q_rec.flags.len_addr   = (count_reg >= CNT_W'(MIN_ADDR_LEN));
        q_rec.flags.len_config = (count_reg >= CNT_W'(MIN_CONFIG_LEN));
        q_rec.flags.len_match  = ({1'b0, len_reg} == len_expect);
    end

endmodule

`default_nettype wire

// ----- rtl/tfr_queue.sv -----
// ----------------------------------------------------------------------------
// tfr_queue
// two-entry queue of closed frames between the front and the decoder
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_queue
    import tfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire frame_rec_t push_rec,
    output logic            full,
    input  wire logic       pop,
    output logic            head_valid,
    output frame_rec_t      head_rec
);

    frame_rec_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg, fill_next;

    assign full       = (fill_reg == 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_rec   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tfr_back.sv -----
// ----------------------------------------------------------------------------
// tfr_back
// checks a closed frame, applies its command and registers the result
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_back
    import tfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire frame_rec_t  head_rec,
    output logic             pop,
    input  wire logic [15:0] coord,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata
);

    logic [7:0] light_reg, motion_reg, mute_reg;
    logic       configured_reg;
    logic [7:0] light_next, motion_next, mute_next;
    logic       configured_next;
    logic [1:0] action;
    logic       addr_ok;
    logic       out_valid_reg;
    logic [1:0] out_action_reg;
    logic [7:0] out_light_reg, out_motion_reg, out_mute_reg;
    logic       out_configured_reg;

    assign pop = head_valid && (!out_valid_reg || m_axis_tready);

    assign addr_ok = head_rec.flags.len_addr && head_rec.flags.len_match
                     && (head_rec.src == coord);

    always_comb
    begin
        action = ACT_DROP;
        if (head_rec.hdr == HDR_ADDRESSED)
        begin
            if (addr_ok)
            begin
                if (head_rec.op == OP_SETTINGS)
                begin
                    action = head_rec.flags.len_config ? ACT_SET : ACT_DROP;
                end
                else if (head_rec.op == OP_PING)
                begin
                    action = ACT_HELLO;
                end
            end
        end
        else if (head_rec.hdr == HDR_BROADCAST)
        begin
            if (head_rec.flags.len_bcast && (head_rec.bcast_op == OP_PING))
            begin
                action = ACT_HELLO;
            end
        end
    end

    always_comb
    begin
        light_next      = light_reg;
        motion_next     = motion_reg;
        mute_next       = mute_reg;
        configured_next = configured_reg;
        if (pop && (action == ACT_SET))
        begin
            light_next      = head_rec.light;
            motion_next     = head_rec.motion;
            mute_next       = head_rec.mute;
            configured_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg      <= '0;
            motion_reg     <= '0;
            mute_reg       <= '0;
            configured_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            light_reg      <= light_next;
            motion_reg     <= motion_next;
            mute_reg       <= mute_next;
            configured_reg <= configured_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_action_reg     <= action;
            out_light_reg      <= light_next;
            out_motion_reg     <= motion_next;
            out_mute_reg       <= mute_next;
            out_configured_reg <= configured_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_configured_reg, out_mute_reg, out_motion_reg,
                            out_light_reg, out_action_reg};

endmodule

`default_nettype wire

// ----- rtl/timed_frame_receiver_command_decoder.sv -----
// ----------------------------------------------------------------------------
// timed_frame_receiver_command_decoder
// collects a timed frame of received bytes and decodes its command
// ----------------------------------------------------------------------------
//  channel  | direction | tdata fields (low bit up)                 | tuser
//  s_axis   | in        | rx_byte[7:0]                              | func
//  m_axis   | out       | action[1:0] light_enable[9:2]             | -
//           |           | motion_enable[17:10] mute_setting[25:18]  |
//           |           | configured_flag[26], zero fill [31:27]    |
//  cfg      | in        | cfg_index 0 window_tick_limit, 1 coordinator_address
//
//  one request per cycle while s_axis_tready is high; the front end stores a byte or counts a tick as it is accepted
//  a closing tick's result passes through the frame queue and the output register before it is valid on m_axis
//  s_axis_tready drops only while the two-entry frame queue is full
//  rst_n clears counters, settings and the queue; limit resets to 6
// ----------------------------------------------------------------------------
`default_nettype none

module timed_frame_receiver_command_decoder
    import tfr_pkg::*;
#(
    parameter int FRAME_DEPTH = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte
    input  wire logic        s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // action, light, motion, mute, configured
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    logic [7:0]  limit_reg;
    logic [15:0] coord_reg;
    logic        q_push, q_full, q_pop, q_valid;
    frame_rec_t  push_rec, head_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 8'd6;
            coord_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_LIMIT: limit_reg <= cfg_wdata[7:0];
                CFG_IDX_COORD: coord_reg <= cfg_wdata;
                default:       limit_reg <= limit_reg;
            endcase
        end
    end

    tfr_front #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .limit         (limit_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_rec         (push_rec)
    );

    tfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_rec   (push_rec),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_rec   (head_rec)
    );

    tfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_valid),
        .head_rec      (head_rec),
        .pop           (q_pop),
        .coord         (coord_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // a closed frame never lands on a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("frame pushed into full queue");

    // a settings result always reports the block as configured
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == ACT_SET)) |-> m_axis_tdata[26])
        else $error("settings result without configured flag");

    // a waiting result is not replaced before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- tb/tb_timed_frame_receiver_command_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timed_frame_receiver_command_decoder
// feeds received bytes and timer ticks into the frame decoder while both
// stream sides stall at random, and checks every reply of a closing tick
// against an untimed model of the window, the frame checks and the settings
// ----------------------------------------------------------------------------

import tfr_pkg::*;

typedef struct packed {
    logic       configured;
    logic [7:0] mute;
    logic [7:0] motion;
    logic [7:0] light;
    logic [1:0] action;
} reply_t;

class frame_decode_calc;
    logic [7:0]  frame_bytes[];
    int unsigned depth;
    int unsigned byte_total;
    logic [7:0]  ticks;
    bit          window_open;
    logic [7:0]  light;
    logic [7:0]  motion;
    logic [7:0]  mute;
    bit          configured;
    logic [7:0]  tick_limit;
    logic [15:0] coord_addr;
    reply_t      pending_replies[$];
    int          requests_used;
    int          replies_made;
    int          replies_seen;
    int          mismatches;

    function new(int unsigned store_depth);
        depth = store_depth;
        frame_bytes = new[store_depth];
        byte_total = 0;
        ticks = 8'd0;
        window_open = 1'b0;
        light = 8'd0;
        motion = 8'd0;
        mute = 8'd0;
        configured = 1'b0;
        tick_limit = 8'd6;    // window limit comes out of reset at 6
        coord_addr = 16'h0000;
        requests_used = 0;
        replies_made = 0;
        replies_seen = 0;
        mismatches = 0;
    endfunction

    function void set_regs(logic [7:0] limit, logic [15:0] coord);
        tick_limit = limit;
        coord_addr = coord;
    endfunction

    function logic [1:0] decode_frame();
        int unsigned n;
        logic [15:0] src;
        n = byte_total;
        if (frame_bytes[IDX_HDR] == HDR_ADDRESSED) begin
            if (n < MIN_ADDR_LEN)
                return ACT_DROP;
            if (32'(frame_bytes[IDX_LEN]) != n - ADDR_OVERHEAD)
                return ACT_DROP;
            // source address sits in the last two bytes, high byte first
            src = {frame_bytes[n - 2], frame_bytes[n - 1]};
            if (src != coord_addr)
                return ACT_DROP;
            if (frame_bytes[IDX_OP] == OP_PING)
                return ACT_HELLO;
            if (frame_bytes[IDX_OP] != OP_SETTINGS || n < MIN_CONFIG_LEN)
                return ACT_DROP;
            light = frame_bytes[IDX_LIGHT];
            motion = frame_bytes[IDX_MOTION];
            mute = frame_bytes[IDX_MUTE];
            configured = 1'b1;
            return ACT_SET;
        end
        if (frame_bytes[IDX_HDR] == HDR_BROADCAST && n >= MIN_BCAST_LEN
            && frame_bytes[IDX_BCAST_OP] == OP_PING)
            return ACT_HELLO;
        return ACT_DROP;
    endfunction

    function void note_request(logic is_tick, logic [7:0] data);
        reply_t r;
        if (!is_tick) begin
            requests_used++;
            if (byte_total == 0) begin
                ticks = 8'd0;
                window_open = 1'b1;
            end
            // bytes past the end of the store are dropped
            if (byte_total < depth) begin
                frame_bytes[byte_total] = data;
                byte_total++;
            end
            return;
        end
        if (!window_open)
            return;
        requests_used++;
        ticks++;
        if (ticks <= tick_limit)
            return;
        r.action = decode_frame();
        byte_total = 0;
        window_open = 1'b0;
        r.light = light;
        r.motion = motion;
        r.mute = mute;
        r.configured = configured;
        pending_replies.push_back(r);
        replies_made++;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("reply %0d: %s expected %0h got %0h", replies_seen, name, want, got);
        end
    endfunction

    function void check_reply(logic [31:0] word);
        reply_t want;
        reply_t got;
        got = word[$bits(reply_t) - 1:0];
        if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("reply %h arrived with none outstanding", word);
            return;
        end
        want = pending_replies.pop_front();
        replies_seen++;
        compare_field("action", 8'(want.action), 8'(got.action));
        compare_field("light_enable", want.light, got.light);
        compare_field("motion_enable", want.motion, got.motion);
        compare_field("mute_setting", want.mute, got.mute);
        compare_field("configured_flag", 8'(want.configured), 8'(got.configured));
        compare_field("zero fill", 8'd0, 8'(word[31:$bits(reply_t)]));
    endfunction
endclass

module tb_timed_frame_receiver_command_decoder;

    localparam int FRAME_DEPTH     = 64;
    localparam int SETTLE_CYCLES   = 8;
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_REQUESTS = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // rx_byte
    logic        s_axis_tuser = 1'b0;      // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;             // action, light, motion, mute, configured
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_IDX_LIMIT;
    logic [15:0] cfg_wdata = 16'h0000;

    bit          no_idle = 1'b0;
    int          stall_cycles = 0;
    int          settings_tried = 1;
    logic [7:0]  frame_buf[$];
    frame_decode_calc decode_calc;

    always #10 clk = ~clk;

    timed_frame_receiver_command_decoder #(
        .FRAME_DEPTH(FRAME_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always @(posedge clk)
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 11);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            decode_calc.check_reply(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic bit take_gap();
        return !no_idle && ($urandom_range(0, 99) < 11);
    endfunction

    task automatic send_request(input logic is_tick, input logic [7:0] data);
        while (take_gap())
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= is_tick;
        s_axis_tdata <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        decode_calc.note_request(is_tick, data);
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_request(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_frame_buf();
        foreach (frame_buf[i])
            send_request(1'b0, frame_buf[i]);
        frame_buf.delete();
    endtask

    // let the reply queue drain before touching the registers
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (decode_calc.pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [7:0] limit, input logic [15:0] coord);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_LIMIT;
        cfg_wdata <= {8'h00, limit};
        @(posedge clk);
        cfg_index <= CFG_IDX_COORD;
        cfg_wdata <= coord;
        @(posedge clk);
        cfg_we <= 1'b0;
        decode_calc.set_regs(limit, coord);
        settings_tried++;
    endtask

    task automatic make_addressed(input logic [7:0] op, input int body_len,
                                  input logic [15:0] src);
        frame_buf.delete();
        frame_buf.push_back(HDR_ADDRESSED);
        frame_buf.push_back(8'(body_len + MIN_ADDR_LEN - ADDR_OVERHEAD));
        frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf.push_back(op);
        repeat (body_len)
            frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf.push_back(src[15:8]);
        frame_buf.push_back(src[7:0]);
    endtask

    task automatic make_broadcast(input logic [7:0] op, input int total_len);
        frame_buf.delete();
        frame_buf.push_back(HDR_BROADCAST);
        frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf.push_back(op);
        repeat (total_len - 3)
            frame_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic random_frame();
        int pick;
        int len;
        logic [7:0] op;
        logic [15:0] flip;
        pick = $urandom_range(0, 99);
        flip = 16'($urandom_range(1, 65535));
        if (pick < 40)
            make_addressed(OP_SETTINGS, $urandom_range(3, 6), decode_calc.coord_addr);
        else if (pick < 55)
            make_addressed(OP_PING, $urandom_range(0, 4), decode_calc.coord_addr);
        else if (pick < 65)
        begin
            op = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : OP_PING;
            make_broadcast(op, $urandom_range(3, 8));
        end
        else if (pick < 85)
        begin
            case ($urandom_range(0, 4))
                0: make_addressed(OP_SETTINGS, $urandom_range(0, 2), decode_calc.coord_addr);
                1:
                begin
                    make_addressed(OP_SETTINGS, $urandom_range(3, 5), decode_calc.coord_addr);
                    frame_buf[IDX_LEN] = frame_buf[IDX_LEN] ^ 8'($urandom_range(1, 255));
                end
                2: make_addressed(8'($urandom_range(0, 1)), $urandom_range(3, 5),
                                  decode_calc.coord_addr ^ flip);
                3: make_addressed(8'($urandom_range(2, 255)), $urandom_range(0, 5),
                                  decode_calc.coord_addr);
                default:
                begin
                    // addressed header but shorter than the minimum frame
                    frame_buf.delete();
                    frame_buf.push_back(HDR_ADDRESSED);
                    repeat ($urandom_range(0, MIN_ADDR_LEN - 2))
                        frame_buf.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        else
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(FRAME_DEPTH - 4, FRAME_DEPTH + 6)
                                               : $urandom_range(1, 12);
            frame_buf.delete();
            repeat (len)
                frame_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // mostly just enough ticks to close, sometimes too few so the next frame
    // runs on, sometimes extra ones that land while idle
    task automatic close_window();
        int count;
        if (decode_calc.tick_limit == 8'd255)
            count = $urandom_range(0, 3);
        else if ($urandom_range(0, 9) == 0)
            count = $urandom_range(0, decode_calc.tick_limit);
        else
            count = decode_calc.tick_limit + 1
                    + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
        send_ticks(count);
    endtask

    task automatic run_phase(input logic [7:0] limit, input logic [15:0] coord,
                             input int budget);
        int stop;
        settle();
        program_regs(limit, coord);
        stop = decode_calc.requests_used + budget;
        while (decode_calc.requests_used < stop)
        begin
            random_frame();
            send_frame_buf();
            close_window();
        end
    endtask

    initial
    begin
        int random_start;
        decode_calc = new(FRAME_DEPTH);
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);

        // reset limit and reset address: seven ticks close an addressed ping
        make_addressed(OP_PING, 0, 16'h0000);
        send_frame_buf();
        send_ticks(7);
        settle();
        program_regs(8'd0, 16'hFFFF);
        make_addressed(OP_SETTINGS, 3, 16'hFFFF);
        frame_buf[IDX_LIGHT] = 8'hFF;
        frame_buf[IDX_MOTION] = 8'h00;
        frame_buf[IDX_MUTE] = 8'hFF;
        send_frame_buf();
        send_ticks(1);
        make_broadcast(OP_PING, MIN_BCAST_LEN);
        frame_buf[IDX_LEN] = 8'hFF;
        send_frame_buf();
        send_ticks(2);

        random_start = decode_calc.requests_used;
        run_phase(8'd1, 16'h0000, 75);
        // window never closes, so bytes pile up past the store depth
        run_phase(8'd255, 16'hFFFF, 90);
        run_phase(8'd0, 16'($urandom_range(0, 65535)), 75);
        no_idle <= 1'b1;
        run_phase(8'd4, 16'($urandom_range(0, 65535)), 75);
        no_idle <= 1'b0;
        settle();
        program_regs(8'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
        while (decode_calc.requests_used - random_start < RANDOM_REQUESTS)
        begin
            random_frame();
            send_frame_buf();
            close_window();
        end

        settle();
        $display("ran %0d byte and tick requests under %0d register settings",
                 decode_calc.requests_used, settings_tried);
        $display("checked %0d of %0d closed frames, %0d mismatches",
                 decode_calc.replies_seen, decode_calc.replies_made,
                 decode_calc.mismatches);
        if (decode_calc.mismatches == 0 && decode_calc.pending_replies.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- timed_frame_receiver_command_decoder.f -----
rtl/tfr_pkg.sv
rtl/tfr_front.sv
rtl/tfr_queue.sv
rtl/tfr_back.sv
rtl/timed_frame_receiver_command_decoder.sv
tb/tb_timed_frame_receiver_command_decoder.sv
